/* rtl/core/fragment_header_parser_assert.svh */
// Assertion macros shared by the fragment header parser RTL.
// No dependencies; included by the modules that carry checks.
`ifndef FRAGMENT_HEADER_PARSER_ASSERT_SVH
`define FRAGMENT_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fhp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fhp assertion failed");

`endif

/* rtl/core/fhp_pkg.sv */
// Package for the fragment header parser: item types, codes and constants.
// No dependencies.
package fhp_pkg;

    // Largest data length that a fragment may announce
    localparam int unsigned MAX_DATA = 1024;

    localparam int unsigned NUM_W   = 16;
    localparam int unsigned SIZE_W  = 11;
    localparam int unsigned INDEX_W = 10;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Saturation limit of the numeric fields
    localparam logic [NUM_W-1:0] NUM_SAT = '1;

    typedef enum logic [2:0] {
        PH_TOTAL  = 3'd0,
        PH_NUMBER = 3'd1,
        PH_SIZE   = 3'd2,
        PH_NAME   = 3'd3,
        PH_DATA   = 3'd4,
        PH_AFTER  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        CL_HEADER  = 3'd0,
        CL_NAME    = 3'd1,
        CL_DATA    = 3'd2,
        CL_IGNORED = 3'd3,
        CL_ERROR   = 3'd4
    } t_byte_class;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } t_in_item;

    typedef struct packed {
        t_byte_class        byte_class;
        logic [7:0]         out_byte;
        logic [NUM_W-1:0]   total_frags;
        logic [NUM_W-1:0]   fragment_number;
        logic [SIZE_W-1:0]  data_size;
        logic [INDEX_W-1:0] data_index;
        logic               last_data;
        logic               transfer_done;
    } t_out_item;

endpackage

/* rtl/core/fragment_header_parser.sv */
// Top level of the fragment header parser: input register, parser, result register.
// Depends on fhp_pkg and fhp_parser.

// Takes one datagram byte per item and returns one result item per byte, telling
// whether the byte belongs to the header, the filename or the data (with its index),
// is ignored, or falls in an error. Throughput is one item per clock cycle while the
// result register is not held by a low i_out_ready. A byte accepted into the input
// register is parsed out of it and lands in the result register once that register is
// free, and its result is then offered on o_out_valid. The rate is set by the parse
// state loop, which updates once per item. While a result waits, the input register
// still takes one more byte before o_in_ready falls. Asserting packet_start on a byte
// restarts the parse at that byte.
module fragment_header_parser
    import fhp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_in_vld, n_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld, n_out_vld;
    t_out_item r_out_item;
    t_out_item w_res;
    logic      w_out_free;
    logic      w_adv;
    logic      w_take;

    // Handshake: the input stage moves on when the result register is free
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_adv      = r_in_vld && w_out_free;
    assign o_in_ready = !r_in_vld || w_out_free;
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        n_in_vld  = w_take ? 1'b1 : (w_adv ? 1'b0 : r_in_vld);
        n_out_vld = w_adv ? 1'b1 : (i_out_ready ? 1'b0 : r_out_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_item <= i_in_item;
        end
        if (w_adv) begin
            r_out_item <= w_res;
        end
    end

    fhp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_in_item),
        .o_res   (w_res)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

/* rtl/core/fhp_parser.sv */
// Parse state of the fragment header parser and the per-byte step logic.
// Depends on fhp_pkg and fragment_header_parser_assert.svh.
`include "fragment_header_parser_assert.svh"

module fhp_parser
    import fhp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_in_item  i_item,
    output t_out_item o_res
);

    t_phase             r_phase,      n_phase;
    logic [NUM_W-1:0]   r_acc,        n_acc;
    logic               r_has_digit,  n_has_digit;
    logic [NUM_W-1:0]   r_total,      n_total;
    logic [NUM_W-1:0]   r_number,     n_number;
    logic [SIZE_W-1:0]  r_size,       n_size;
    logic [SIZE_W-1:0]  r_data_count, n_data_count;
    logic               r_error,      n_error;

    // State as seen by this item: a packet start clears the parse first
    t_phase             c_phase;
    logic [NUM_W-1:0]   c_acc;
    logic               c_has_digit;
    logic [NUM_W-1:0]   c_total;
    logic [NUM_W-1:0]   c_number;
    logic [SIZE_W-1:0]  c_size;
    logic [SIZE_W-1:0]  c_data_count;
    logic               c_error;

    logic               w_is_digit;
    logic [NUM_W+3:0]   w_acc_next;
    logic [SIZE_W-1:0]  w_count_inc;

    always_comb begin
        if (i_item.packet_start) begin
            c_phase      = PH_TOTAL;
            c_acc        = '0;
            c_has_digit  = 1'b0;
            c_total      = '0;
            c_number     = '0;
            c_size       = '0;
            c_data_count = '0;
            c_error      = 1'b0;
        end else begin
            c_phase      = r_phase;
            c_acc        = r_acc;
            c_has_digit  = r_has_digit;
            c_total      = r_total;
            c_number     = r_number;
            c_size       = r_size;
            c_data_count = r_data_count;
            c_error      = r_error;
        end
    end

    // acc * 10 + digit, as 8x + 2x
    assign w_is_digit  = (i_item.data_byte >= CH_ZERO) && (i_item.data_byte <= CH_NINE);
    assign w_acc_next  = {1'b0, c_acc, 3'b000} + {3'b000, c_acc, 1'b0}
                       + {NUM_W'(0), (i_item.data_byte[3:0] - CH_ZERO[3:0])};
    assign w_count_inc = c_data_count + SIZE_W'(1);

    // One parse step
    always_comb begin
        n_phase      = c_phase;
        n_acc        = c_acc;
        n_has_digit  = c_has_digit;
        n_total      = c_total;
        n_number     = c_number;
        n_size       = c_size;
        n_data_count = c_data_count;
        n_error      = c_error;

        o_res.byte_class = CL_IGNORED;
        o_res.data_index = '0;
        o_res.last_data  = 1'b0;
        o_res.transfer_done = 1'b0;

        if (c_error) begin
            o_res.byte_class = CL_ERROR;
        end else begin
            unique case (c_phase)
                PH_TOTAL, PH_NUMBER, PH_SIZE: begin
                    if (w_is_digit) begin
                        n_acc = (w_acc_next > {4'b0000, NUM_SAT}) ? NUM_SAT
                                                                  : w_acc_next[NUM_W-1:0];
                        n_has_digit = 1'b1;
                        o_res.byte_class = CL_HEADER;
                    end else if ((i_item.data_byte == CH_COLON) && c_has_digit) begin
                        n_acc       = '0;
                        n_has_digit = 1'b0;
                        priority if (c_phase == PH_TOTAL) begin
                            n_total = c_acc;
                            n_phase = PH_NUMBER;
                            o_res.byte_class = CL_HEADER;
                        end else if (c_phase == PH_NUMBER) begin
                            n_number = c_acc;
                            n_phase  = PH_SIZE;
                            o_res.byte_class = CL_HEADER;
                        end else if (32'(c_acc) > MAX_DATA) begin
                            n_error = 1'b1;
                            o_res.byte_class = CL_ERROR;
                        end else begin
                            n_size  = c_acc[SIZE_W-1:0];
                            n_phase = PH_NAME;
                            o_res.byte_class = CL_HEADER;
                        end
                    end else begin
                        n_error = 1'b1;
                        o_res.byte_class = CL_ERROR;
                    end
                end
                PH_NAME: begin
                    if (i_item.data_byte == CH_COLON) begin
                        o_res.byte_class = CL_HEADER;
                        n_data_count = '0;
                        if (c_size == '0) begin
                            o_res.last_data     = 1'b1;
                            o_res.transfer_done = (c_number == c_total);
                            n_phase = PH_AFTER;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else begin
                        o_res.byte_class = CL_NAME;
                    end
                end
                PH_DATA: begin
                    o_res.byte_class = CL_DATA;
                    o_res.data_index = c_data_count[INDEX_W-1:0];
                    n_data_count = w_count_inc;
                    if (w_count_inc >= c_size) begin
                        o_res.last_data     = 1'b1;
                        o_res.transfer_done = (c_number == c_total);
                        n_phase = PH_AFTER;
                    end
                end
                default: begin
                    o_res.byte_class = CL_IGNORED;
                end
            endcase
        end

        // Fields reported with the byte take the state after this step
        o_res.out_byte        = i_item.data_byte;
        o_res.total_frags     = n_total;
        o_res.fragment_number = n_number;
        o_res.data_size       = n_size;
    end

    // State registers, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TOTAL;
            r_acc        <= '0;
            r_has_digit  <= 1'b0;
            r_total      <= '0;
            r_number     <= '0;
            r_size       <= '0;
            r_data_count <= '0;
            r_error      <= 1'b0;
        end else if (i_adv) begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_has_digit  <= n_has_digit;
            r_total      <= n_total;
            r_number     <= n_number;
            r_size       <= n_size;
            r_data_count <= n_data_count;
            r_error      <= n_error;
        end
    end

    // An error holds until the next packet start
    `FHP_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, i_adv && r_error && !i_item.packet_start, r_error)
    // Inside the data phase the count stays below the announced size
    `FHP_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, r_phase == PH_DATA, r_data_count < r_size)
    // Without an item the parse state does not move
    `FHP_ASSERT_NEXT(a_idle_stable, i_clk, i_rst_n, !i_adv, $stable(r_phase) && $stable(r_data_count))

endmodule
